// File: rtl/text_console_writer_assert.svh
// assertion macros shared by the console rtl
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("console assertion failed");

// consequence that must hold in the cycle after the trigger
`define TCW_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("console assertion failed");

`endif

// File: rtl/tcw_pkg.sv
// constants, codes and types of the text console writer
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;
	localparam int COL_FW = 7;
	localparam int ROW_FW = 5;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

	typedef enum logic [1:0] {
		MODE_SCROLL = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_INIT   = 2'd2
	} sweep_mode_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic              sweep_start;
		sweep_mode_t       mode;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] wdata;
	} tcw_cmd_t;

endpackage

// File: rtl/tcw_if.sv
// request, response and configuration channels of the console
interface tcw_req_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] character;
	logic              use_cursor;
	logic [COL_FW-1:0] col;
	logic [ROW_FW-1:0] row;
	logic [ATTR_W-1:0] attribute;

	modport source (output valid, req_type, character, use_cursor, col, row, attribute,
		input ready);
	modport sink (input valid, req_type, character, use_cursor, col, row, attribute,
		output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_FW-1:0] cursor_col;
	logic [ROW_FW-1:0] cursor_row;
	logic              scrolled;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;

	modport source (output valid, cursor_col, cursor_row, scrolled, read_char, read_attr,
		input ready);
	modport sink (input valid, cursor_col, cursor_row, scrolled, read_char, read_attr,
		output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/tcw_screen.sv
// screen cell store with a one cell per cycle sweep for scroll, clear and init
`include "text_console_writer_assert.svh"

module tcw_screen import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_cmd_t          cmd,
	output logic              busy,
	output logic [CELL_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		SEL_MOVE = 2'd0,
		SEL_FILL = 2'd1,
		SEL_ZERO = 2'd2
	} sel_t;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;

	logic [ADDR_W-1:0] idx_q;
	logic              issue_q;
	sweep_mode_t       mode_q;
	logic [CELL_W-1:0] fill_q;

	logic              wr_s1;
	logic [ADDR_W-1:0] addr_s1;
	sel_t              sel_s1;

	logic              top_rows;
	sel_t              sel_next;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	assign top_rows = idx_q < ADDR_W'(CELLS - COLUMNS);

	always_comb begin
		unique case (mode_q)
			MODE_SCROLL: sel_next = top_rows ? SEL_MOVE : SEL_ZERO;
			MODE_CLEAR:  sel_next = top_rows ? SEL_FILL : SEL_ZERO;
			default:     sel_next = SEL_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			issue_q <= 1'b1;
			mode_q  <= MODE_INIT;
			wr_s1   <= 1'b0;
		end else begin
			wr_s1 <= issue_q;
			if (issue_q) begin
				if (idx_q == ADDR_W'(CELLS - 1)) begin
					issue_q <= 1'b0;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + ADDR_W'(1);
				end
			end else if (cmd.sweep_start) begin
				issue_q <= 1'b1;
				mode_q  <= cmd.mode;
				idx_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		sel_s1  <= sel_next;
		if (cmd.sweep_start) begin
			fill_q <= cmd.wdata;
		end
	end

	always_comb begin
		we    = wr_s1 | cmd.wr_en;
		waddr = wr_s1 ? addr_s1 : cmd.addr;
		if (wr_s1) begin
			unique case (sel_s1)
				SEL_MOVE: wdata = rdata_q;
				SEL_FILL: wdata = fill_q;
				default:  wdata = '0;
			endcase
		end else begin
			wdata = cmd.wdata;
		end
		re    = (issue_q && sel_next == SEL_MOVE) || cmd.rd_en;
		raddr = issue_q ? ADDR_W'(idx_q + ADDR_W'(COLUMNS)) : cmd.addr;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign busy    = issue_q | wr_s1;
	assign rd_data = rdata_q;

	`TCW_ASSERT_NEXT(a_no_cell_write_in_sweep, cmd.wr_en, !$past(busy))
	`TCW_ASSERT_ALWAYS(a_no_start_in_sweep, !(cmd.sweep_start && busy))
	`TCW_ASSERT_ALWAYS(a_sweep_addr_range, !wr_s1 || addr_s1 <= ADDR_W'(CELLS - 1))

endmodule

// File: rtl/text_console_writer.sv
// top level of the text console writer: request sequencer, cursor and result register
// put, read, unused request type: ST_ADDR, ST_EXEC, ST_DONE; the next request waits for ST_IDLE
// put that scrolls and clear: an added ST_SWEEP state while the screen store sweeps
//   one cell per cycle through its single write and single read port
// reset: cursor home, default attribute 15, then a clearing pass that zeroes the screen
//   before the first request transfer
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ADDR  = 6'b000100,
		ST_EXEC  = 6'b001000,
		ST_SWEEP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [ATTR_W-1:0] def_attr_q;
	logic              out_valid_q;

	logic [REQ_W-1:0]  req_q;
	logic [CHAR_W-1:0] char_q;
	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  tcol_q;
	logic [ROW_W-1:0]  trow_q;
	logic [ADDR_W-1:0] addr_q;
	logic              scrolled_q;

	logic [COL_FW-1:0] out_col_q;
	logic [ROW_FW-1:0] out_row_q;
	logic              out_scrolled_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [ATTR_W-1:0] out_attr_q;

	tcw_cmd_t          cmd;
	logic              busy;
	logic [CELL_W-1:0] rd_data;

	logic              in_xfer;
	logic              out_free;
	logic              is_newline;
	logic              wrap;
	logic              last_row;
	logic [COL_W-1:0]  sat_col;
	logic [ROW_W-1:0]  sat_row;

	tcw_screen u_screen (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.busy    (busy),
		.rd_data (rd_data)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign sat_col = (req.col > COL_FW'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(req.col);
	assign sat_row = (req.row > ROW_FW'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(req.row);

	assign is_newline = (char_q == NEWLINE_CODE);
	assign wrap       = is_newline || (tcol_q == COL_W'(COLUMNS - 1));
	assign last_row   = (trow_q == ROW_W'(ROWS - 1));

	always_comb begin
		cmd             = '0;
		cmd.mode        = MODE_SCROLL;
		cmd.addr        = addr_q;
		cmd.wdata       = {attr_q, char_q};
		if (state_q == ST_EXEC) begin
			unique case (req_q)
				REQ_PUT: begin
					cmd.wr_en       = !is_newline;
					cmd.sweep_start = wrap && last_row;
				end
				REQ_READ: begin
					cmd.rd_en = 1'b1;
				end
				REQ_CLEAR: begin
					cmd.sweep_start = 1'b1;
					cmd.mode        = MODE_CLEAR;
					cmd.wdata       = {def_attr_q, SPACE_CODE};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_attr_q <= DEFAULT_ATTR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			def_attr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (!busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					unique case (req_q)
						REQ_PUT: begin
							if (!wrap) begin
								cursor_col_q <= tcol_q + COL_W'(1);
								cursor_row_q <= trow_q;
								state_q      <= ST_DONE;
							end else begin
								cursor_col_q <= '0;
								if (last_row) begin
									cursor_row_q <= trow_q;
									state_q      <= ST_SWEEP;
								end else begin
									cursor_row_q <= trow_q + ROW_W'(1);
									state_q      <= ST_DONE;
								end
							end
						end
						REQ_CLEAR: begin
							cursor_col_q <= '0;
							cursor_row_q <= '0;
							state_q      <= ST_SWEEP;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_SWEEP: begin
					if (!busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q  <= req.req_type;
			char_q <= req.character;
			attr_q <= (req.attribute == '0) ? def_attr_q : req.attribute;
			tcol_q <= req.use_cursor ? cursor_col_q : sat_col;
			trow_q <= req.use_cursor ? cursor_row_q : sat_row;
		end
		if (state_q == ST_ADDR) begin
			addr_q <= ADDR_W'(ADDR_W'(trow_q) * ADDR_W'(COLUMNS)) + ADDR_W'(tcol_q);
		end
		if (state_q == ST_EXEC) begin
			scrolled_q <= ((req_q == REQ_PUT) && wrap && last_row) || (req_q == REQ_CLEAR);
		end
		if (state_q == ST_DONE && out_free) begin
			out_col_q      <= COL_FW'(cursor_col_q);
			out_row_q      <= ROW_FW'(cursor_row_q);
			out_scrolled_q <= scrolled_q;
			out_char_q     <= (req_q == REQ_READ) ? rd_data[CHAR_W-1:0] : '0;
			out_attr_q     <= (req_q == REQ_READ) ? rd_data[CELL_W-1:CHAR_W] : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.scrolled   = out_scrolled_q;
	assign rsp.read_char  = out_char_q;
	assign rsp.read_attr  = out_attr_q;

	`TCW_ASSERT_ALWAYS(a_cursor_range,
		cursor_col_q < COL_W'(COLUMNS) && cursor_row_q < ROW_W'(ROWS))
	`TCW_ASSERT_ALWAYS(a_no_transfer_in_sweep, !(busy && req.ready))
	`TCW_ASSERT_NEXT(a_result_loaded, state_q == ST_DONE && out_free,
		out_valid_q && state_q == ST_IDLE)

endmodule
